// ----- rtl/core/alu8f_pkg.sv -----
// Shared constants and operation codes for the 8-bit ALU with flags.
`timescale 1ns / 1ps

package alu8f_pkg;

  localparam int CmdWidth  = 5;
  localparam int WordWidth = 16;
  localparam int ByteWidth = 8;
  localparam int PosWidth  = 3;

  // Operation codes
  localparam logic [CmdWidth-1:0] CMD_ADD   = 5'd0;
  localparam logic [CmdWidth-1:0] CMD_ADC   = 5'd1;
  localparam logic [CmdWidth-1:0] CMD_SUB   = 5'd2;
  localparam logic [CmdWidth-1:0] CMD_SBC   = 5'd3;
  localparam logic [CmdWidth-1:0] CMD_AND   = 5'd4;
  localparam logic [CmdWidth-1:0] CMD_XOR   = 5'd5;
  localparam logic [CmdWidth-1:0] CMD_OR    = 5'd6;
  localparam logic [CmdWidth-1:0] CMD_CP    = 5'd7;
  localparam logic [CmdWidth-1:0] CMD_INC   = 5'd8;
  localparam logic [CmdWidth-1:0] CMD_DEC   = 5'd9;
  localparam logic [CmdWidth-1:0] CMD_CPL   = 5'd10;
  localparam logic [CmdWidth-1:0] CMD_SCF   = 5'd11;
  localparam logic [CmdWidth-1:0] CMD_CCF   = 5'd12;
  localparam logic [CmdWidth-1:0] CMD_DAA   = 5'd13;
  localparam logic [CmdWidth-1:0] CMD_RLCA  = 5'd14;
  localparam logic [CmdWidth-1:0] CMD_RRCA  = 5'd15;
  localparam logic [CmdWidth-1:0] CMD_RLA   = 5'd16;
  localparam logic [CmdWidth-1:0] CMD_RRA   = 5'd17;
  localparam logic [CmdWidth-1:0] CMD_RLC   = 5'd18;
  localparam logic [CmdWidth-1:0] CMD_RRC   = 5'd19;
  localparam logic [CmdWidth-1:0] CMD_RL    = 5'd20;
  localparam logic [CmdWidth-1:0] CMD_RR    = 5'd21;
  localparam logic [CmdWidth-1:0] CMD_SLA   = 5'd22;
  localparam logic [CmdWidth-1:0] CMD_SRA   = 5'd23;
  localparam logic [CmdWidth-1:0] CMD_SWAP  = 5'd24;
  localparam logic [CmdWidth-1:0] CMD_SRL   = 5'd25;
  localparam logic [CmdWidth-1:0] CMD_BIT   = 5'd26;
  localparam logic [CmdWidth-1:0] CMD_RES   = 5'd27;
  localparam logic [CmdWidth-1:0] CMD_SET   = 5'd28;
  localparam logic [CmdWidth-1:0] CMD_ADD16 = 5'd29;
  localparam logic [CmdWidth-1:0] CMD_ADDSP = 5'd30;

  // Decimal adjust constants
  localparam logic [ByteWidth-1:0] DAA_LO_CORR = 8'h06;
  localparam logic [ByteWidth-1:0] DAA_HI_CORR = 8'h60;
  localparam logic [ByteWidth-1:0] DAA_BCD_MAX = 8'h99;
  localparam logic [3:0]           DAA_DIG_MAX = 4'h9;

  // Flag set carried down the pipeline
  typedef struct packed {
    logic zero;
    logic subtract;
    logic half;
    logic carry;
  } flags_t;

endpackage

// ----- rtl/core/eight_bit_alu_with_flags_top.sv -----
// Top level of the 8-bit ALU with Z/N/H/C flags: three-stage pipeline.
`timescale 1ns / 1ps

// Flag-producing ALU of an 8-bit CPU. A transaction is taken on every clock
// edge where start is high; busy never rises, so a new operation may follow
// in the very next cycle. Each result appears on value_out and the flag
// outputs once its transaction has passed the stage 1, stage 2 and output
// registers, for one cycle, marked by done; the receiver cannot stall it and
// must take it then. The datapath has three register stages: operand decode
// and decimal-adjust correction, the 16-bit carry-chain adder with the
// logic and shift unit, and zero detection with the final flag selection.
// Results leave in the order their transactions arrived.
module eight_bit_alu_with_flags_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  cmd,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [2:0]  bit_position,
  input  logic        zero_in,
  input  logic        subtract_in,
  input  logic        half_in,
  input  logic        carry_in,
  output logic        done,
  output logic [15:0] value_out,
  output logic        zero_out,
  output logic        subtract_out,
  output logic        half_out,
  output logic        carry_out
);

  // ---------------------------------------------------------------------
  // Stage 1: decode operands for the shared adder
  // ---------------------------------------------------------------------
  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [7:0]  daa_corr;
  logic        daa_c_next;
  logic [15:0] add_a_next;
  logic [15:0] add_x_next;
  logic        add_cin_next;
  logic [7:0]  mask_next;

  logic                  s1_valid;
  logic [4:0]            s1_cmd;
  logic [15:0]           s1_a16;
  logic [7:0]            s1_b8;
  logic [7:0]            s1_mask;
  logic [15:0]           s1_add_a;
  logic [15:0]           s1_add_x;
  logic                  s1_add_cin;
  logic                  s1_daa_c;
  alu8f_pkg::flags_t     s1_flags;

  assign busy = 1'b0;
  assign a8   = operand_a[7:0];
  assign b8   = operand_b[7:0];

  // Build the decimal-adjust correction and its carry
  always_comb begin
    daa_corr   = '0;
    daa_c_next = carry_in;
    if (half_in || (!subtract_in && (a8[3:0] > alu8f_pkg::DAA_DIG_MAX))) begin
      daa_corr = daa_corr | alu8f_pkg::DAA_LO_CORR;
    end
    if (carry_in || (!subtract_in && (a8 > alu8f_pkg::DAA_BCD_MAX))) begin
      daa_corr   = daa_corr | alu8f_pkg::DAA_HI_CORR;
      daa_c_next = 1'b1;
    end
  end

  // Select adder inputs; subtraction adds the complement with carry set (SBC uses the inverted carry flag)
  always_comb begin
    add_a_next   = {8'h00, a8};
    add_x_next   = '0;
    add_cin_next = 1'b0;
    case (cmd)
      alu8f_pkg::CMD_ADD: begin
        add_x_next = {8'h00, b8};
      end
      alu8f_pkg::CMD_ADC: begin
        add_x_next   = {8'h00, b8};
        add_cin_next = carry_in;
      end
      alu8f_pkg::CMD_SUB, alu8f_pkg::CMD_CP: begin
        add_x_next   = {8'h00, ~b8};
        add_cin_next = 1'b1;
      end
      alu8f_pkg::CMD_SBC: begin
        add_x_next   = {8'h00, ~b8};
        add_cin_next = !carry_in;
      end
      alu8f_pkg::CMD_INC: begin
        add_x_next = 16'h0001;
      end
      alu8f_pkg::CMD_DEC: begin
        add_x_next = 16'h00FF;
      end
      alu8f_pkg::CMD_DAA: begin
        if (subtract_in) begin
          add_x_next   = {8'h00, ~daa_corr};
          add_cin_next = 1'b1;
        end else begin
          add_x_next = {8'h00, daa_corr};
        end
      end
      alu8f_pkg::CMD_ADD16: begin
        add_a_next = operand_a;
        add_x_next = operand_b;
      end
      alu8f_pkg::CMD_ADDSP: begin
        add_a_next = operand_a;
        add_x_next = {{8{b8[7]}}, b8};
      end
      default: begin
        add_x_next = '0;
      end
    endcase
  end

  assign mask_next = 8'(8'h01 << bit_position);

  // Advance stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_cmd     <= cmd;
    s1_a16     <= operand_a;
    s1_b8      <= b8;
    s1_mask    <= mask_next;
    s1_add_a   <= add_a_next;
    s1_add_x   <= add_x_next;
    s1_add_cin <= add_cin_next;
    s1_daa_c   <= daa_c_next;
    s1_flags   <= '{zero: zero_in, subtract: subtract_in, half: half_in,
                    carry: carry_in};
  end

  // ---------------------------------------------------------------------
  // Stage 2: adder in nibble segments, logic and shift unit, value select
  // ---------------------------------------------------------------------
  logic [4:0]  seg0;
  logic [4:0]  seg1;
  logic [4:0]  seg2;
  logic [4:0]  seg3;
  logic [15:0] sum16;
  logic [7:0]  sum8;
  logic        c4;
  logic        c8;
  logic        c12;
  logic        c16;
  logic [7:0]  a;

  logic [15:0]       value_next;
  logic [7:0]        zbyte_next;
  logic              zuse_next;
  alu8f_pkg::flags_t flags_next;

  logic              s2_valid;
  logic [15:0]       s2_value;
  logic [7:0]        s2_zbyte;
  logic              s2_zuse;
  alu8f_pkg::flags_t s2_flags;

  assign seg0  = {1'b0, s1_add_a[3:0]} + {1'b0, s1_add_x[3:0]} + {4'h0, s1_add_cin};
  assign seg1  = {1'b0, s1_add_a[7:4]} + {1'b0, s1_add_x[7:4]} + {4'h0, seg0[4]};
  assign seg2  = {1'b0, s1_add_a[11:8]} + {1'b0, s1_add_x[11:8]} + {4'h0, seg1[4]};
  assign seg3  = {1'b0, s1_add_a[15:12]} + {1'b0, s1_add_x[15:12]} + {4'h0, seg2[4]};
  assign sum16 = {seg3[3:0], seg2[3:0], seg1[3:0], seg0[3:0]};
  assign sum8  = sum16[7:0];
  assign c4    = seg0[4];
  assign c8    = seg1[4];
  assign c12   = seg2[4];
  assign c16   = seg3[4];
  assign a     = s1_a16[7:0];

  // Select the value and the flags per operation
  always_comb begin
    value_next = s1_a16;
    zbyte_next = '0;
    zuse_next  = 1'b0;
    flags_next = s1_flags;
    case (s1_cmd)
      alu8f_pkg::CMD_ADD, alu8f_pkg::CMD_ADC: begin
        value_next          = {8'h00, sum8};
        zbyte_next          = sum8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = c4;
        flags_next.carry    = c8;
      end
      alu8f_pkg::CMD_SUB, alu8f_pkg::CMD_SBC: begin
        value_next          = {8'h00, sum8};
        zbyte_next          = sum8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b1;
        flags_next.half     = !c4;
        flags_next.carry    = !c8;
      end
      alu8f_pkg::CMD_CP: begin
        value_next          = {8'h00, a};
        zbyte_next          = sum8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b1;
        flags_next.half     = !c4;
        flags_next.carry    = !c8;
      end
      alu8f_pkg::CMD_AND: begin
        value_next          = {8'h00, a & s1_b8};
        zbyte_next          = a & s1_b8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b1;
        flags_next.carry    = 1'b0;
      end
      alu8f_pkg::CMD_XOR: begin
        value_next          = {8'h00, a ^ s1_b8};
        zbyte_next          = a ^ s1_b8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = 1'b0;
      end
      alu8f_pkg::CMD_OR: begin
        value_next          = {8'h00, a | s1_b8};
        zbyte_next          = a | s1_b8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = 1'b0;
      end
      alu8f_pkg::CMD_INC: begin
        value_next          = {8'h00, sum8};
        zbyte_next          = sum8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = c4;
      end
      alu8f_pkg::CMD_DEC: begin
        value_next          = {8'h00, sum8};
        zbyte_next          = sum8;
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b1;
        flags_next.half     = !c4;
      end
      alu8f_pkg::CMD_CPL: begin
        value_next          = {8'h00, ~a};
        flags_next.subtract = 1'b1;
        flags_next.half     = 1'b1;
      end
      alu8f_pkg::CMD_SCF: begin
        value_next          = {8'h00, a};
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = 1'b1;
      end
      alu8f_pkg::CMD_CCF: begin
        value_next          = {8'h00, a};
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = !s1_flags.carry;
      end
      alu8f_pkg::CMD_DAA: begin
        value_next       = {8'h00, sum8};
        zbyte_next       = sum8;
        zuse_next        = 1'b1;
        flags_next.half  = 1'b0;
        flags_next.carry = s1_daa_c;
      end
      alu8f_pkg::CMD_RLCA, alu8f_pkg::CMD_RLC: begin
        value_next          = {8'h00, a[6:0], a[7]};
        zbyte_next          = {a[6:0], a[7]};
        zuse_next           = (s1_cmd == alu8f_pkg::CMD_RLC);
        flags_next.zero     = 1'b0;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[7];
      end
      alu8f_pkg::CMD_RRCA, alu8f_pkg::CMD_RRC: begin
        value_next          = {8'h00, a[0], a[7:1]};
        zbyte_next          = {a[0], a[7:1]};
        zuse_next           = (s1_cmd == alu8f_pkg::CMD_RRC);
        flags_next.zero     = 1'b0;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[0];
      end
      alu8f_pkg::CMD_RLA, alu8f_pkg::CMD_RL: begin
        value_next          = {8'h00, a[6:0], s1_flags.carry};
        zbyte_next          = {a[6:0], s1_flags.carry};
        zuse_next           = (s1_cmd == alu8f_pkg::CMD_RL);
        flags_next.zero     = 1'b0;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[7];
      end
      alu8f_pkg::CMD_RRA, alu8f_pkg::CMD_RR: begin
        value_next          = {8'h00, s1_flags.carry, a[7:1]};
        zbyte_next          = {s1_flags.carry, a[7:1]};
        zuse_next           = (s1_cmd == alu8f_pkg::CMD_RR);
        flags_next.zero     = 1'b0;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[0];
      end
      alu8f_pkg::CMD_SLA: begin
        value_next          = {8'h00, a[6:0], 1'b0};
        zbyte_next          = {a[6:0], 1'b0};
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[7];
      end
      alu8f_pkg::CMD_SRA: begin
        value_next          = {8'h00, a[7], a[7:1]};
        zbyte_next          = {a[7], a[7:1]};
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[0];
      end
      alu8f_pkg::CMD_SWAP: begin
        value_next          = {8'h00, a[3:0], a[7:4]};
        zbyte_next          = {a[3:0], a[7:4]};
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = 1'b0;
      end
      alu8f_pkg::CMD_SRL: begin
        value_next          = {8'h00, 1'b0, a[7:1]};
        zbyte_next          = {1'b0, a[7:1]};
        zuse_next           = 1'b1;
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b0;
        flags_next.carry    = a[0];
      end
      alu8f_pkg::CMD_BIT: begin
        value_next          = {8'h00, a};
        flags_next.zero     = ((a & s1_mask) == 8'h00);
        flags_next.subtract = 1'b0;
        flags_next.half     = 1'b1;
      end
      alu8f_pkg::CMD_RES: begin
        value_next = {8'h00, a & ~s1_mask};
      end
      alu8f_pkg::CMD_SET: begin
        value_next = {8'h00, a | s1_mask};
      end
      alu8f_pkg::CMD_ADD16: begin
        value_next          = sum16;
        flags_next.subtract = 1'b0;
        flags_next.half     = c12;
        flags_next.carry    = c16;
      end
      alu8f_pkg::CMD_ADDSP: begin
        value_next          = sum16;
        flags_next.zero     = 1'b0;
        flags_next.subtract = 1'b0;
        flags_next.half     = c4;
        flags_next.carry    = c8;
      end
      default: begin
        value_next = s1_a16;
      end
    endcase
  end

  // Advance stage 2
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_value <= value_next;
    s2_zbyte <= zbyte_next;
    s2_zuse  <= zuse_next;
    s2_flags <= flags_next;
  end

  // ---------------------------------------------------------------------
  // Stage 3: zero detect and output registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
    value_out    <= s2_value;
    zero_out     <= s2_zuse ? (s2_zbyte == 8'h00) : s2_flags.zero;
    subtract_out <= s2_flags.subtract;
    half_out     <= s2_flags.half;
    carry_out    <= s2_flags.carry;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##3 done)
    else $error("accepted transaction did not complete after three cycles");

  a_no_phantom : assert property (@(posedge clk) disable iff (rst)
    !start |-> ##3 !done)
    else $error("result strobe without an accepted transaction");

  a_add16_flags : assert property (@(posedge clk) disable iff (rst)
    done && $past(start && (cmd == alu8f_pkg::CMD_ADD16), 3)
      |-> !subtract_out && (zero_out == $past(zero_in, 3)))
    else $error("16-bit add altered zero flag or set subtract");

  a_addsp_flags : assert property (@(posedge clk) disable iff (rst)
    done && $past(start && (cmd == alu8f_pkg::CMD_ADDSP), 3)
      |-> !zero_out && !subtract_out)
    else $error("offset add left zero or subtract set");

  a_byte_high_zero : assert property (@(posedge clk) disable iff (rst)
    done && $past(start && (cmd == alu8f_pkg::CMD_SUB || cmd == alu8f_pkg::CMD_DAA), 3)
      |-> value_out[15:8] == 8'h00)
    else $error("byte operation produced nonzero high byte");

endmodule
